/* hw/rtl/sfrd_pkg.sv */
// ----------------------------------------------------------------------------
// sfrd_pkg: shared types and constants of the serial frame receiver
// Holds the result codes, the configuration register map, the frame layout
// and the structs that pass between the receiver and its frame decoder.
// ----------------------------------------------------------------------------
package sfrd_pkg;

  localparam int FrameBytes  = 7;   // bytes 0..6 are kept; byte 7 is the footer
  localparam int CountWidth  = 3;
  localparam int SumBytes    = 6;   // the sum covers bytes 0..5

  localparam logic [7:0] HbCmd      = 8'hC0;
  localparam logic [7:0] HbOnes     = 8'hFF;
  localparam logic [7:0] HbZero     = 8'h00;
  localparam logic [7:0] WakeByte   = 8'h88;
  localparam logic [2:0] UnitMask   = 3'h7;
  localparam logic [4:0] TempOffset = 5'd16;

  typedef enum logic [3:0] {
    KIND_BAD_HEADER = 4'd0,
    KIND_BAD_FOOTER = 4'd1,
    KIND_BAD_SUM    = 4'd2,
    KIND_HEARTBEAT  = 4'd3,
    KIND_SWITCH     = 4'd4,
    KIND_AIRCON     = 4'd5,
    KIND_OTHER_ID   = 4'd6,
    KIND_TIME       = 4'd7,
    KIND_WAKEUP     = 4'd8,
    KIND_VOICE      = 4'd9,
    KIND_UNKNOWN    = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    CFG_HEADER   = 3'd0,
    CFG_FOOTER   = 3'd1,
    CFG_SWITCH   = 3'd2,
    CFG_AIRCON   = 3'd3,
    CFG_TIMESYNC = 3'd4,
    CFG_VOICE    = 3'd5,
    CFG_UNIT_ID  = 3'd6
  } cfg_reg_t;

  typedef logic [FrameBytes-1:0][7:0] frame_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] footer_byte;
    logic [7:0] switch_code;
    logic [7:0] aircon_code;
    logic [7:0] timesync_code;
    logic [7:0] voice_code;
    logic [2:0] unit_id;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  panel_num;
    logic [7:0]  lights_mask;
    logic        ac_power;
    logic [1:0]  ac_mode_bits;
    logic [1:0]  ac_fan_bits;
    logic [4:0]  target_temp;
    logic [4:0]  room_temp;
    logic [31:0] payload_word;
  } res_t;

endpackage

/* hw/rtl/serial_frame_receiver_decoder.sv */
// ----------------------------------------------------------------------------
// serial_frame_receiver_decoder: bus byte framer and message decoder
// Hunts for the header byte, collects an 8-byte frame, checks it and reports
// one decoded result per frame, or a bad-header result per stray byte.
// ----------------------------------------------------------------------------
// A frame's last byte or a stray byte has its result registered in the main
// register, or in the skid entry if that is full and not drained. Throughput:
// one byte per cycle while the skid entry is empty; the frame state is updated
// in one pass. A two-entry output buffer keeps the input open while one result
// waits. Reset (rst, synchronous, active high) returns to header hunting,
// empties the output buffer and clears all configuration registers to zero.
module serial_frame_receiver_decoder (
  input  logic        clk,
  input  logic        rst,

  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,

  // Received byte channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,

  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic [7:0]  panel_num,
  output logic [7:0]  lights_mask,
  output logic        ac_power,
  output logic [1:0]  ac_mode_bits,
  output logic [1:0]  ac_fan_bits,
  output logic [4:0]  target_temp,
  output logic [4:0]  room_temp,
  output logic [31:0] payload_word
);

  // Configuration registers.
  sfrd_pkg::cfg_t cfg;

  // Frame collection state.
  logic                            in_frame;
  logic [sfrd_pkg::CountWidth-1:0] byte_count;
  sfrd_pkg::frame_t                frame_store;
  logic [7:0]                      running_sum;

  // Output buffer: a main result register and a skid entry behind it.
  sfrd_pkg::res_t out_res;
  sfrd_pkg::res_t skid_res;
  logic           skid_valid;

  logic           accept;
  logic           frame_end;
  logic           stray_byte;
  logic           push;
  logic           pop;
  sfrd_pkg::res_t dec_res;
  sfrd_pkg::res_t new_res;

  // Configuration writes are always taken. Indexes beyond the map are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (sfrd_pkg::cfg_reg_t'(cfg_index))
        sfrd_pkg::CFG_HEADER:   cfg.header_byte   <= cfg_data;
        sfrd_pkg::CFG_FOOTER:   cfg.footer_byte   <= cfg_data;
        sfrd_pkg::CFG_SWITCH:   cfg.switch_code   <= cfg_data;
        sfrd_pkg::CFG_AIRCON:   cfg.aircon_code   <= cfg_data;
        sfrd_pkg::CFG_TIMESYNC: cfg.timesync_code <= cfg_data;
        sfrd_pkg::CFG_VOICE:    cfg.voice_code    <= cfg_data;
        sfrd_pkg::CFG_UNIT_ID:  cfg.unit_id       <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // The input stays open until the skid entry is occupied, so bytes that
  // produce no result keep flowing even while a result waits downstream.
  assign in_ready   = !skid_valid;
  assign accept     = in_valid && in_ready;
  assign frame_end  = in_frame && (byte_count == sfrd_pkg::CountWidth'(sfrd_pkg::FrameBytes));
  assign stray_byte = !in_frame && (rx_byte != cfg.header_byte);
  assign push       = accept && (frame_end || stray_byte);
  assign pop        = out_valid && out_ready;

  // Frame collection. A header value inside a frame is plain data; the
  // eighth byte always sends the receiver back to hunting.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      byte_count  <= '0;
      running_sum <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        if (rx_byte == cfg.header_byte) begin
          in_frame    <= 1'b1;
          byte_count  <= sfrd_pkg::CountWidth'(1);
          running_sum <= rx_byte;
        end
      end else if (frame_end) begin
        in_frame   <= 1'b0;
        byte_count <= '0;
      end else begin
        byte_count <= byte_count + sfrd_pkg::CountWidth'(1);
        if (byte_count < sfrd_pkg::CountWidth'(sfrd_pkg::SumBytes)) begin
          running_sum <= running_sum + rx_byte;
        end
      end
    end
  end

  // Frame bytes are payload and need no reset; every frame writes bytes 0..6
  // before the decoder looks at them.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!in_frame) begin
        frame_store[0] <= rx_byte;
      end else if (!frame_end) begin
        frame_store[byte_count] <= rx_byte;
      end
    end
  end

  sfrd_decode u_decode (
    .frame       (frame_store),
    .last_byte   (rx_byte),
    .running_sum (running_sum),
    .cfg         (cfg),
    .res         (dec_res)
  );

  // A stray byte reports bad header with every other field zero.
  always_comb begin
    if (in_frame) begin
      new_res = dec_res;
    end else begin
      new_res      = '0;
      new_res.kind = sfrd_pkg::KIND_BAD_HEADER;
    end
  end

  // Output buffer control. The skid entry only fills when the main register
  // is full and not being drained; it refills the main register on the next
  // drain, while the input is held off.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_res <= new_res;
      end else begin
        out_res <= new_res;
      end
    end
  end

  assign kind         = out_res.kind;
  assign panel_num    = out_res.panel_num;
  assign lights_mask  = out_res.lights_mask;
  assign ac_power     = out_res.ac_power;
  assign ac_mode_bits = out_res.ac_mode_bits;
  assign ac_fan_bits  = out_res.ac_fan_bits;
  assign target_temp  = out_res.target_temp;
  assign room_temp    = out_res.room_temp;
  assign payload_word = out_res.payload_word;

  // The skid entry is only ever occupied behind a full main register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while main result register is empty");

  // The byte counter is zero exactly while hunting for a header.
  a_count_matches_frame: assert property (@(posedge clk) disable iff (rst)
    in_frame == (byte_count != '0))
    else $error("byte counter disagrees with frame state");

  // The last byte of a frame always returns the receiver to hunting.
  a_frame_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end) |=> !in_frame)
    else $error("receiver did not return to hunting after a frame");

  // A request that produces a result leaves a result waiting.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("result lost after an accepted request");

endmodule

/* hw/rtl/sfrd_decode.sv */
// ----------------------------------------------------------------------------
// sfrd_decode: frame checker and classifier
// Checks header, footer and checksum of a complete frame and sorts a good
// frame into its message kind, extracting the fields that kind carries.
// ----------------------------------------------------------------------------
module sfrd_decode (
  input  sfrd_pkg::frame_t frame,
  input  logic [7:0]       last_byte,
  input  logic [7:0]       running_sum,
  input  sfrd_pkg::cfg_t   cfg,
  output sfrd_pkg::res_t   res
);

  logic [31:0] word;
  logic        is_heartbeat;
  logic        is_wakeup;

  assign word = {frame[2], frame[3], frame[4], frame[5]};

  assign is_heartbeat = (frame[1] == sfrd_pkg::HbCmd) && (frame[2] == sfrd_pkg::HbOnes) &&
                        (frame[3] == sfrd_pkg::HbOnes) && (frame[4] == sfrd_pkg::HbZero);

  assign is_wakeup = (frame[1] == sfrd_pkg::WakeByte) && (frame[2] == sfrd_pkg::WakeByte) &&
                     (frame[3] == sfrd_pkg::WakeByte) && (frame[4] == sfrd_pkg::WakeByte) &&
                     (frame[5] == sfrd_pkg::WakeByte);

  // First match wins, in the order the protocol defines.
  always_comb begin
    res = '0;
    if (frame[0] != cfg.header_byte || last_byte != cfg.footer_byte) begin
      res.kind = sfrd_pkg::KIND_BAD_FOOTER;
    end else if (frame[6] != running_sum) begin
      res.kind = sfrd_pkg::KIND_BAD_SUM;
    end else if (is_heartbeat) begin
      res.kind = sfrd_pkg::KIND_HEARTBEAT;
    end else if (frame[1] == cfg.switch_code) begin
      res.kind        = sfrd_pkg::KIND_SWITCH;
      res.panel_num   = frame[3];
      res.lights_mask = frame[5];
    end else if (frame[1] == cfg.aircon_code) begin
      if ((frame[4][2:0] & sfrd_pkg::UnitMask) != cfg.unit_id) begin
        res.kind = sfrd_pkg::KIND_OTHER_ID;
      end else begin
        res.kind         = sfrd_pkg::KIND_AIRCON;
        res.ac_power     = frame[4][7];
        res.ac_mode_bits = frame[4][6:5];
        res.ac_fan_bits  = frame[4][4:3];
        res.target_temp  = {1'b0, frame[5][7:4]} + sfrd_pkg::TempOffset;
        res.room_temp    = {1'b0, frame[5][3:0]} + sfrd_pkg::TempOffset;
      end
    end else if (frame[1] == cfg.timesync_code) begin
      res.kind         = sfrd_pkg::KIND_TIME;
      res.payload_word = word;
    end else if (is_wakeup) begin
      res.kind = sfrd_pkg::KIND_WAKEUP;
    end else if (frame[1] == cfg.voice_code) begin
      res.kind         = sfrd_pkg::KIND_VOICE;
      res.payload_word = word;
    end else begin
      res.kind = sfrd_pkg::KIND_UNKNOWN;
    end
  end

endmodule
